// ===== sv/sbda_pkg.sv =====
// Package for the signed binary to decimal ASCII core.
// Holds the micro-op and branch-condition codes, the control word and the microcode ROM.
// No dependencies.
`timescale 1ns / 1ps

package sbda_pkg;

  localparam int VALUE_W   = 64;
  localparam int DIGITS    = 20;
  localparam int BCD_W     = DIGITS * 4;
  localparam int BITCNT_W  = 7;
  localparam int DIGCNT_W  = 5;
  localparam int STEP_W    = 3;
  localparam int CHAR_W    = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_DABBLE,
    OP_SKIP,
    OP_SIGN,
    OP_DIGIT,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_START,
    C_BITS_LEFT,
    C_LEAD_ZERO,
    C_MORE_DIGITS
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic start;
    logic bits_more;
    logic lead_zero;
    logic more_digits;
  } flags_t;

  localparam step_t S_WAIT   = 3'd0;
  localparam step_t S_DABBLE = 3'd1;
  localparam step_t S_SKIP   = 3'd2;
  localparam step_t S_SIGN   = 3'd3;
  localparam step_t S_DIGIT  = 3'd4;
  localparam step_t S_RET    = 3'd5;

  // Branch taken -> target, else fall through to step + 1.
  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t cw;
    case (step)
      S_WAIT:   cw = '{op: OP_WAIT,   cond: C_NO_START,    target: S_WAIT};
      S_DABBLE: cw = '{op: OP_DABBLE, cond: C_BITS_LEFT,   target: S_DABBLE};
      S_SKIP:   cw = '{op: OP_SKIP,   cond: C_LEAD_ZERO,   target: S_SKIP};
      S_SIGN:   cw = '{op: OP_SIGN,   cond: C_ALWAYS,      target: S_DIGIT};
      S_DIGIT:  cw = '{op: OP_DIGIT,  cond: C_MORE_DIGITS, target: S_DIGIT};
      S_RET:    cw = '{op: OP_NOP,    cond: C_ALWAYS,      target: S_WAIT};
      default:  cw = '{op: OP_NOP,    cond: C_ALWAYS,      target: S_WAIT};
    endcase
    return cw;
  endfunction

endpackage

// ===== sv/sbda_seq.sv =====
// Microcode sequencer: step counter, ROM lookup and conditional branch.
// Depends on sbda_pkg.
`timescale 1ns / 1ps

module sbda_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  sbda_pkg::flags_t      flags,
  output sbda_pkg::ctrl_word_t  cw
);

  sbda_pkg::step_t step;
  sbda_pkg::step_t step_next;
  logic            taken;

  assign cw = sbda_pkg::ucode_rom(step);

  always_comb begin
    case (cw.cond)
      sbda_pkg::C_ALWAYS:      taken = 1'b1;
      sbda_pkg::C_NO_START:    taken = !flags.start;
      sbda_pkg::C_BITS_LEFT:   taken = flags.bits_more;
      sbda_pkg::C_LEAD_ZERO:   taken = flags.lead_zero;
      sbda_pkg::C_MORE_DIGITS: taken = flags.more_digits;
      default:                 taken = 1'b1;
    endcase
    step_next = taken ? cw.target : step + sbda_pkg::step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= sbda_pkg::S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== sv/signed_binary_to_decimal_ascii_core.sv =====
// Signed 64-bit binary to decimal ASCII, microcoded double-dabble.
// Steps in order: dabble steps over the value bits, leading-zero skip, optional minus sign, then the digits.
// Busy until back in the wait step; a new word is taken only there, not while a word is in flight.
// Characters come one per cycle on strobe; the receiver cannot stall.
// Reset (rst, sync) returns the sequencer to its wait step and drops strobe.
// Depends on sbda_pkg and sbda_seq.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [sbda_pkg::VALUE_W-1:0] value,
  output logic                               strobe,
  output logic [sbda_pkg::CHAR_W-1:0]        text_char,
  output logic                               last_char
);

  sbda_pkg::ctrl_word_t cw;
  sbda_pkg::flags_t     flags;

  // Datapath registers
  logic [sbda_pkg::VALUE_W-1:0]  mag;      // magnitude, shifted out MSB first
  logic                          neg;
  logic [sbda_pkg::BCD_W-1:0]    bcd;      // 20 BCD digits, top digit is next to print
  logic [sbda_pkg::BITCNT_W-1:0] bitcnt;   // dabble steps left
  logic [sbda_pkg::DIGCNT_W-1:0] dcnt;     // digits left in bcd

  logic [sbda_pkg::BCD_W-1:0]    bcd_adj;
  logic [3:0]                    top_digit;
  logic [sbda_pkg::VALUE_W-1:0]  value_mag;

  sbda_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  assign busy = (cw.op != sbda_pkg::OP_WAIT);

  // Unsigned negate: the most negative value maps to 2^63 correctly.
  assign value_mag = value[sbda_pkg::VALUE_W-1] ? (~value + 64'd1) : value;

  assign top_digit = bcd[sbda_pkg::BCD_W-1 -: 4];

  // Add-3 correction on every digit that is 5 or more, ahead of the shift.
  always_comb begin
    for (int i = 0; i < sbda_pkg::DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    flags.start       = start;
    flags.bits_more   = (bitcnt != sbda_pkg::BITCNT_W'(1));
    // Leading zeros are dropped, but the last digit always stays (zero prints '0').
    flags.lead_zero   = (top_digit == 4'd0) && (dcnt != sbda_pkg::DIGCNT_W'(1));
    flags.more_digits = (dcnt != sbda_pkg::DIGCNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (cw.op)
        sbda_pkg::OP_WAIT: begin
          if (start) begin
            mag    <= value_mag;
            neg    <= value[sbda_pkg::VALUE_W-1];
            bcd    <= '0;
            bitcnt <= sbda_pkg::BITCNT_W'(sbda_pkg::VALUE_W);
            dcnt   <= sbda_pkg::DIGCNT_W'(sbda_pkg::DIGITS);
          end
        end
        sbda_pkg::OP_DABBLE: begin
          bcd    <= {bcd_adj[sbda_pkg::BCD_W-2:0], mag[sbda_pkg::VALUE_W-1]};
          mag    <= {mag[sbda_pkg::VALUE_W-2:0], 1'b0};
          bitcnt <= bitcnt - sbda_pkg::BITCNT_W'(1);
        end
        sbda_pkg::OP_SKIP: begin
          if (flags.lead_zero) begin
            bcd  <= {bcd[sbda_pkg::BCD_W-5:0], 4'd0};
            dcnt <= dcnt - sbda_pkg::DIGCNT_W'(1);
          end
        end
        sbda_pkg::OP_SIGN: begin
          if (neg) begin
            strobe    <= 1'b1;
            text_char <= sbda_pkg::CHAR_MINUS;
            last_char <= 1'b0;     // a digit always follows
          end
        end
        sbda_pkg::OP_DIGIT: begin
          strobe    <= 1'b1;
          text_char <= sbda_pkg::CHAR_ZERO + {2'b00, top_digit};
          last_char <= (dcnt == sbda_pkg::DIGCNT_W'(1));
          bcd       <= {bcd[sbda_pkg::BCD_W-5:0], 4'd0};
          dcnt      <= dcnt - sbda_pkg::DIGCNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench for signed_binary_to_decimal_ascii_core: a directed table, then random words; rows without
// literal text and all random words go to an in-bench predictor, and every character is checked.
// Depends on sbda_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_WORDS = 480;
  localparam int DRAIN_CYCLES = 120;
  localparam int TABLE_ROWS   = 20;
  localparam logic [63:0] DEC_RADIX = 64'd10;

  typedef struct {
    logic [sbda_pkg::CHAR_W-1:0] code;
    logic                        last;
  } text_char_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic signed [sbda_pkg::VALUE_W-1:0] value = '0;
  logic                                busy;
  logic                                strobe;
  logic [sbda_pkg::CHAR_W-1:0]         text_char;
  logic                                last_char;

  text_char_t pending_chars [$];   // expected characters, oldest first
  int         mismatches = 0;
  int         words_sent = 0;
  int         negative_words = 0;
  int         chars_seen = 0;

  signed_binary_to_decimal_ascii_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .text_char (text_char),
    .last_char (last_char)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Directed table. A non-empty string is the literal expected text; an empty one
  // leaves the row to the predictor.
  logic [63:0] table_value [TABLE_ROWS] = '{
    64'd0,
    64'd1,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001,
    64'd9,
    -64'sd9,
    64'd10,
    -64'sd10,
    64'd99,
    64'd100,
    64'd1000000000000000000,
    64'd999999999999999999,
    64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h0000_0000_FFFF_FFFF,
    64'hFFFF_FFFF_0000_0000,
    64'd1234567890,
    -64'sd1234567890
  };
  string table_text [TABLE_ROWS] = '{
    "0", "1", "-1", "9223372036854775807", "-9223372036854775808",
    "-9223372036854775807", "9", "-9", "10", "-10", "99", "100",
    "1000000000000000000", "999999999999999999",
    "", "", "", "", "", ""
  };

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  function automatic void push_char(input logic [sbda_pkg::CHAR_W-1:0] code, input logic last);
    text_char_t c;
    c.code = code;
    c.last = last;
    pending_chars.push_back(c);
  endfunction

  // Decimal text of a two's complement word. The magnitude is taken unsigned, so
  // the most negative word prints in full.
  function automatic void predict_text(input logic [63:0] word);
    logic [63:0] mag;
    logic [3:0]  digits [$];
    logic        neg;
    int          total;
    int          n;
    neg = word[63];
    mag = neg ? (64'd0 - word) : word;
    // do-while gives the lone '0' for a zero word
    do begin
      digits.push_front(4'(mag % DEC_RADIX));
      mag = mag / DEC_RADIX;
    end while (mag != 64'd0);
    total = digits.size() + (neg ? 1 : 0);
    n = 0;
    if (neg) begin
      n++;
      push_char(sbda_pkg::CHAR_MINUS, n == total);
    end
    foreach (digits[i]) begin
      n++;
      push_char(sbda_pkg::CHAR_ZERO + sbda_pkg::CHAR_W'(digits[i]), n == total);
    end
  endfunction

  function automatic void expect_literal(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      push_char(sbda_pkg::CHAR_W'(txt[i]), i == txt.len() - 1);
    end
  endfunction

  // Mostly short gaps, a few long ones that reach past the end of the busy window,
  // and every third block of 40 words back to back.
  function automatic int pick_gap(input int idx);
    if ((idx / 40) % 3 == 0) begin
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 120);
    end
    return $urandom_range(0, 2);
  endfunction

  // Holds start high until the word is taken; start drops only for a nonzero gap,
  // so back-to-back words never lower and raise start in one step.
  task automatic send_word(input logic [63:0] word, input string literal, input int gap);
    start <= 1'b1;
    value <= word;
    do @(posedge clk); while (busy);
    if (literal.len() != 0) begin
      expect_literal(literal);
    end else begin
      predict_text(word);
    end
    words_sent++;
    if (word[63]) begin
      negative_words++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      value <= {$urandom(), $urandom()};   // noise while idle, must be ignored
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    logic [63:0] p;
    int          kind;
    int          bits;
    kind = $urandom_range(0, 9);
    w = {$urandom(), $urandom()};
    if (kind < 6) begin
      // random magnitude length covers every digit count
      bits = $urandom_range(1, 64);
      if (bits < 64) begin
        w = w & ((64'd1 << bits) - 64'd1);
      end
      if ($urandom_range(0, 1) == 1) begin
        w = 64'd0 - w;
      end
    end else if (kind < 8) begin
      // powers of ten and their neighbors stress the digit-count boundaries
      p = 64'd1;
      repeat ($urandom_range(0, 19)) p = p * DEC_RADIX;
      w = p + 64'($urandom_range(0, 2)) - 64'd1;
      if ($urandom_range(0, 1) == 1) begin
        w = 64'd0 - w;
      end
    end
    return w;
  endfunction

  // Characters are taken on every edge with strobe; the receiver cannot stall.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && strobe) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character %0d with no word pending", text_char));
      end else begin
        want = pending_chars.pop_front();
        if (text_char !== want.code) begin
          report_mismatch($sformatf("text_char got %0d want %0d", text_char, want.code));
        end
        if (last_char !== want.last) begin
          report_mismatch($sformatf("last_char got %b want %b on char %0d",
                                    last_char, want.last, want.code));
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < TABLE_ROWS; r++) begin
      send_word(table_value[r], table_text[r], pick_gap(r + 40));
    end
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      send_word(random_word(), "", pick_gap(i));
    end
    start <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d words (%0d negative), checked %0d characters, %0d mismatches.",
             words_sent, negative_words, chars_seen, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Worst run is about 500 words, each with its longest gap; this allows several times that.
  initial begin
    #1_000_000;
    $display("Timeout with %0d characters outstanding", pending_chars.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sbda_pkg.sv
sv/sbda_seq.sv
sv/signed_binary_to_decimal_ascii_core.sv
tb/testbench.sv
